// ----- design/lbpt_pkg.sv -----
// Shared constants and types of the letter bigram probability table.
package lbpt_pkg;

    localparam int SYMBOL_COUNT = 28;
    localparam int SYM_W        = 5;
    localparam int BYTE_W       = 8;
    localparam int OP_W         = 2;
    localparam int OUT_CNT_W    = 16;
    localparam int PROB_W       = 17;
    localparam int PAIR_DEPTH   = SYMBOL_COUNT * SYMBOL_COUNT;
    localparam int ADDR_W       = $clog2(PAIR_DEPTH);

    localparam logic [SYM_W-1:0] NO_SYMBOL     = 5'd28;
    localparam logic [SYM_W-1:0] SPACE_SYMBOL  = 5'd27;
    localparam logic [SYM_W-1:0] NTILDE_SYMBOL = 5'd14;
    localparam logic [SYM_W-1:0] SYM_A         = 5'd0;
    localparam logic [SYM_W-1:0] SYM_E         = 5'd4;
    localparam logic [SYM_W-1:0] SYM_I         = 5'd8;
    localparam logic [SYM_W-1:0] SYM_O         = 5'd15;
    localparam logic [SYM_W-1:0] SYM_U         = 5'd21;

    typedef enum logic [OP_W-1:0] {
        OP_FEED  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FEED,
        ST_READ_WAIT,
        ST_DIVIDE,
        ST_REPLY
    } t_state;

endpackage

// ----- design/lbpt_if.sv -----
// Valid/ready channel interfaces for the request and result words.
interface lbpt_in_if import lbpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] byte_value;
    logic              text_end;
    logic [SYM_W-1:0]  row_symbol;
    logic [SYM_W-1:0]  col_symbol;

    modport source (
        output valid, operation, byte_value, text_end, row_symbol, col_symbol,
        input  ready
    );
    modport sink (
        input  valid, operation, byte_value, text_end, row_symbol, col_symbol,
        output ready
    );
endinterface

interface lbpt_out_if import lbpt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SYM_W-1:0]     symbol_index;
    logic                 pair_counted;
    logic [OUT_CNT_W-1:0] pair_count;
    logic [OUT_CNT_W-1:0] row_total;
    logic [PROB_W-1:0]    probability;

    modport source (
        output valid, symbol_index, pair_counted, pair_count, row_total, probability,
        input  ready
    );
    modport sink (
        input  valid, symbol_index, pair_counted, pair_count, row_total, probability,
        output ready
    );
endinterface

// ----- design/letter_bigram_probability_table_top.sv -----
// Top level of the letter bigram probability table: control, pair store and row totals.
//
//  Channel | Dir | Word                                                     | Accepted when
//  i_in    | in  | operation, byte_value, text_end, row_symbol, col_symbol  | valid && ready
//  o_out   | out | symbol_index, pair_counted, pair_count, row_total,       | valid && ready
//          |     | probability                                              |
//
// For a fed byte the pair count is read from the store and written back incremented.
// A read's probability is formed by the bit-serial divider at one quotient bit a cycle.
// A clear, and reset, sweep the 784-entry pair store at one entry a cycle; no word is taken then.
// Results go to an output register, so a word is taken while an earlier result waits.
// A result that cannot leave holds the item in its last state until the output is free.
module letter_bigram_probability_table_top import lbpt_pkg::*; #(
    parameter int COUNT_BITS    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lbpt_in_if.sink  i_in,
    lbpt_out_if.source o_out
);

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(PAIR_DEPTH - 1);

    t_state r_state;
    t_state n_state;
    t_op    w_op;

    logic [COUNT_BITS-1:0] r_mem [PAIR_DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [COUNT_BITS-1:0] r_row_tot [SYMBOL_COUNT];

    logic [ADDR_W-1:0]     r_clr_addr;
    logic                  r_reply;
    logic [SYM_W-1:0]      r_prev_sym;
    logic                  r_prev_valid;

    logic [SYM_W-1:0]      r_sym;
    logic                  r_text_end;
    logic                  r_counted;
    logic [ADDR_W-1:0]     r_pair_addr;
    logic                  r_cnt_ok;
    logic [COUNT_BITS-1:0] r_tot;
    logic [COUNT_BITS-1:0] r_cnt;

    logic                  r_out_valid;
    logic [SYM_W-1:0]      r_o_sym;
    logic                  r_o_counted;
    logic [OUT_CNT_W-1:0]  r_o_cnt;
    logic [OUT_CNT_W-1:0]  r_o_tot;
    logic [PROB_W-1:0]     r_o_prob;

    logic [SYM_W-1:0]      w_sym;
    logic                  w_feed_counted;
    logic                  w_row_ok;
    logic                  w_col_ok;
    logic [ADDR_W-1:0]     w_feed_addr;
    logic [ADDR_W-1:0]     w_read_addr;
    logic [SYM_W-1:0]      w_tot_idx;
    logic [COUNT_BITS-1:0] w_tot_rd;
    logic [COUNT_BITS-1:0] w_tot_inc;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic [COUNT_BITS-1:0] w_cnt;

    logic                  w_in_ready;
    logic                  w_accept;
    logic                  w_slot_free;
    logic                  w_out_load;
    logic                  w_mem_we;
    logic [ADDR_W-1:0]     w_mem_waddr;
    logic [COUNT_BITS-1:0] w_mem_wdata;
    logic                  w_mem_re;
    logic [ADDR_W-1:0]     w_mem_raddr;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [FRACTION_BITS:0] w_quotient;

    lbpt_symbol_map u_map (
        .i_byte   (i_in.byte_value),
        .o_symbol (w_sym)
    );

    lbpt_serial_div #(
        .CNT_W  (COUNT_BITS),
        .FRAC_W (FRACTION_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_cnt),
        .i_divisor  (r_tot),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        w_op           = t_op'(i_in.operation);
        w_feed_counted = (w_sym != NO_SYMBOL) && r_prev_valid;
        w_row_ok       = (i_in.row_symbol < SYM_W'(SYMBOL_COUNT));
        w_col_ok       = (i_in.col_symbol < SYM_W'(SYMBOL_COUNT));
        w_feed_addr    = ADDR_W'(r_prev_sym) * ADDR_W'(SYMBOL_COUNT) + ADDR_W'(w_sym);
        w_read_addr    = ADDR_W'(i_in.row_symbol) * ADDR_W'(SYMBOL_COUNT)
                       + ADDR_W'(i_in.col_symbol);
        w_tot_idx      = (r_state == ST_IDLE) ? i_in.row_symbol : r_prev_sym;
        w_tot_rd       = (w_tot_idx < SYM_W'(SYMBOL_COUNT)) ? r_row_tot[w_tot_idx] : '0;
        w_tot_inc      = (w_tot_rd == {COUNT_BITS{1'b1}}) ? w_tot_rd
                                                          : w_tot_rd + COUNT_BITS'(1);
        w_cnt_inc      = (r_rdata == {COUNT_BITS{1'b1}}) ? r_rdata
                                                         : r_rdata + COUNT_BITS'(1);
        w_cnt          = r_cnt_ok ? r_rdata : '0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = r_reply ? ST_REPLY : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_FEED:  n_state = ST_FEED;
                        OP_READ:  n_state = ST_READ_WAIT;
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_REPLY;
                    endcase
                end
            end
            ST_FEED: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ_WAIT: begin
                n_state = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (w_div_done && w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REPLY: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready  = (r_state == ST_IDLE);
        w_accept    = w_in_ready && i_in.valid;
        w_slot_free = !r_out_valid || o_out.ready;
        w_out_load  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_clr_addr;
        w_mem_wdata = '0;
        w_mem_re    = 1'b0;
        w_mem_raddr = w_feed_addr;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_mem_we = 1'b1;
            end
            ST_IDLE: begin
                if (w_accept && w_op == OP_FEED) begin
                    w_mem_re = w_feed_counted;
                end else if (w_accept && w_op == OP_READ) begin
                    w_mem_re    = w_row_ok && w_col_ok;
                    w_mem_raddr = w_read_addr;
                end
            end
            ST_FEED: begin
                w_out_load  = w_slot_free;
                w_mem_we    = w_slot_free && r_counted;
                w_mem_waddr = r_pair_addr;
                w_mem_wdata = w_cnt_inc;
            end
            ST_READ_WAIT: begin
                w_div_start = 1'b1;
            end
            ST_DIVIDE: begin
                w_out_load = w_div_done && w_slot_free;
            end
            ST_REPLY: begin
                w_out_load = w_slot_free;
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_mem[w_mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_reply      <= 1'b0;
            r_prev_sym   <= '0;
            r_prev_valid <= 1'b0;
            r_row_tot    <= '{default: '0};
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (w_accept && w_op == OP_CLEAR) begin
                r_clr_addr   <= '0;
                r_reply      <= 1'b1;
                r_prev_sym   <= '0;
                r_prev_valid <= 1'b0;
                r_row_tot    <= '{default: '0};
            end
            if (r_state == ST_FEED && w_slot_free) begin
                if (r_counted) begin
                    r_row_tot[r_prev_sym] <= w_tot_inc;
                end
                if (r_sym != NO_SYMBOL) begin
                    r_prev_sym   <= r_sym;
                    r_prev_valid <= !r_text_end;
                end else begin
                    r_prev_valid <= 1'b0;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sym       <= w_sym;
            r_text_end  <= i_in.text_end;
            r_counted   <= w_feed_counted;
            r_pair_addr <= w_feed_addr;
            r_cnt_ok    <= w_row_ok && w_col_ok;
            r_tot       <= w_tot_rd;
        end
        if (r_state == ST_READ_WAIT) begin
            r_cnt <= w_cnt;
        end
        if (w_out_load) begin
            if (r_state == ST_FEED) begin
                r_o_sym     <= r_sym;
                r_o_counted <= r_counted;
                r_o_cnt     <= '0;
                r_o_tot     <= '0;
                r_o_prob    <= '0;
            end else if (r_state == ST_DIVIDE) begin
                r_o_sym     <= NO_SYMBOL;
                r_o_counted <= 1'b0;
                r_o_cnt     <= OUT_CNT_W'(r_cnt);
                r_o_tot     <= OUT_CNT_W'(r_tot);
                r_o_prob    <= (r_tot == '0) ? '0 : PROB_W'(w_quotient);
            end else begin
                r_o_sym     <= NO_SYMBOL;
                r_o_counted <= 1'b0;
                r_o_cnt     <= '0;
                r_o_tot     <= '0;
                r_o_prob    <= '0;
            end
        end
    end

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.symbol_index = r_o_sym;
    assign o_out.pair_counted = r_o_counted;
    assign o_out.pair_count   = r_o_cnt;
    assign o_out.row_total    = r_o_tot;
    assign o_out.probability  = r_o_prob;

`ifndef SYNTH
    a_feed_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FEED && w_slot_free) |=> (o_out.valid && r_state == ST_IDLE))
        else $error("Feed result was not posted after write-back.");

    a_cnt_le_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE && w_out_load) |-> (r_cnt <= r_tot))
        else $error("Pair count exceeds its row total.");

    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && r_clr_addr == CLR_LAST) |=> (r_state != ST_CLEAR))
        else $error("Clear sweep ran past the last entry.");
`endif

endmodule

// ----- design/lbpt_symbol_map.sv -----
// Maps a Latin-1 text byte to its bigram symbol.
module lbpt_symbol_map import lbpt_pkg::*; (
    input  logic [BYTE_W-1:0] i_byte,
    output logic [SYM_W-1:0]  o_symbol
);

    logic [BYTE_W-1:0] w_upper;
    logic [BYTE_W-1:0] w_letter;

    always_comb begin
        w_upper = i_byte;
        if (i_byte >= 8'h61 && i_byte <= 8'h7A) begin
            w_upper = i_byte - 8'h20;
        end
        w_letter = w_upper - 8'h41;
        if (w_upper >= 8'h41 && w_upper <= 8'h5A) begin
            // Letters from o onward skip the slot kept for n-tilde.
            o_symbol = (w_letter < 8'd14) ? SYM_W'(w_letter) : SYM_W'(w_letter + 8'd1);
        end else begin
            case (w_upper) inside
                8'h20:               o_symbol = SPACE_SYMBOL;
                8'hC1, 8'hE1:        o_symbol = SYM_A;
                8'hC9, 8'hE9:        o_symbol = SYM_E;
                8'hCD, 8'hED:        o_symbol = SYM_I;
                8'hD3, 8'hF3:        o_symbol = SYM_O;
                8'hFC, 8'hF8, 8'hFA: o_symbol = SYM_U;
                8'hD1, 8'hF1:        o_symbol = NTILDE_SYMBOL;
                default:             o_symbol = NO_SYMBOL;
            endcase
        end
    end

endmodule

// ----- design/lbpt_serial_div.sv -----
// Bit-serial restoring divider that forms a count over its total as a fixed-point fraction.
module lbpt_serial_div #(
    parameter int CNT_W  = 16,
    parameter int FRAC_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CNT_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [FRAC_W:0]   o_quotient
);

    localparam int STEP_W = $clog2(FRAC_W + 1);

    logic [CNT_W:0]    r_rem;
    logic [CNT_W:0]    n_rem;
    logic [CNT_W-1:0]  r_den;
    logic [FRAC_W:0]   r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic              w_ge;
    logic [CNT_W:0]    w_diff;

    always_comb begin
        w_ge   = (r_rem >= {1'b0, r_den});
        w_diff = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;
        n_rem  = {w_diff[CNT_W-1:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_step == STEP_W'(FRAC_W)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
            r_den <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[FRAC_W-1:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
